[rtl/core/fecb_pkg.sv]
// fecb_pkg: shared types and constants of the filtered event counter bank
// depends on nothing
package fecb_pkg;

  localparam logic [23:0] DevMask = 24'hFFFFFF;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_SEL_WR = 2'd1,
    KIND_CNT_WR = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_HPM_ENABLE = 2'd0,
    CFG_INHIBIT = 2'd1,
    CFG_ACTIVE = 2'd2,
    CFG_BITS = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] counter_index;
    logic [14:0] event_id;
    logic proc_valid;
    logic [19:0] proc_id;
    logic pscid_valid;
    logic [19:0] pscid;
    logic [23:0] dev_id;
    logic gscid_valid;
    logic [15:0] gscid;
    logic [3:0] selector_bits;
    logic [63:0] counter_value;
  } in_item_t;

  typedef struct packed {
    logic overflow_irq;
    logic [31:0] overflow_flags;
    logic [31:0] counted_mask;
  } out_item_t;

  typedef struct packed {
    logic [2:0] cfg_index;
    logic [63:0] cfg_data;
  } cfg_item_t;

  // selector word as held in memory
  typedef struct packed {
    logic [14:0] ev;
    logic [19:0] proc_match;
    logic [23:0] dev_match;
    logic pv;
    logic dv;
    logic idt;
    logic dmask;
  } sel_t;

endpackage

[rtl/core/fecb_queue.sv]
// fecb_queue: two-entry queue between front and back
// depends on fecb_pkg
module fecb_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  fecb_pkg::in_item_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output fecb_pkg::in_item_t pop_data
);
  import fecb_pkg::*;

  in_item_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;

  assign full = fill[1];
  assign not_empty = fill != 2'd0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[rtl/core/fecb_back.sv]
// fecb_back: walks the counters one at a time, selectors and values in memory
// depends on fecb_pkg
module fecb_back #(
  parameter int unsigned NUM_COUNTERS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  input  fecb_pkg::in_item_t item,
  output logic item_pop,
  input  logic hpm_enable,
  input  logic [31:0] inhibit_mask,
  input  logic [5:0] active_counters,
  input  logic [6:0] counter_bits,
  output logic res_valid,
  input  logic res_ready,
  output fecb_pkg::out_item_t res
);
  import fecb_pkg::*;

  localparam int unsigned IdxW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_UPD = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  sel_t sel_mem [NUM_COUNTERS];
  logic [63:0] cnt_mem [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] valid_bits;
  logic [NUM_COUNTERS-1:0] of_flags;
  sel_t sel_rd;
  logic [63:0] cnt_rd;
  logic rd_valid;
  logic [IdxW-1:0] idx;
  logic [5:0] limit;
  logic irq;
  logic [31:0] counted;

  logic [6:0] eff_bits;
  logic [63:0] wmask;
  logic idx_ok;
  logic [5:0] idx_ext;
  always_comb begin
    eff_bits = (counter_bits == 7'd0) ? 7'd1 :
               (counter_bits > 7'd64) ? 7'd64 : counter_bits;
    wmask = (eff_bits == 7'd64) ? '1 : ((64'd1 << eff_bits[5:0]) - 64'd1);
    idx_ok = {1'b0, item.counter_index} < 6'(NUM_COUNTERS);
  end

  // filter on the registered selector
  sel_t s;
  logic [63:0] old_v;
  logic [64:0] inc;
  logic [23:0] dmsk;
  logic match;
  logic ovf;
  always_comb begin
    s = rd_valid ? sel_rd : '0;
    old_v = rd_valid ? cnt_rd : '0;
    dmsk = s.dmask ? (~((s.dev_match + 24'd1) ^ s.dev_match) & DevMask) : DevMask;
    match = s.ev == item.event_id;
    if (!s.idt) begin
      if (s.pv && (!item.proc_valid || s.proc_match != item.proc_id)) match = 1'b0;
      if (s.dv && ((s.dev_match & dmsk) != (item.dev_id & dmsk))) match = 1'b0;
    end else begin
      if (s.pv && (!item.pscid_valid || s.proc_match != item.pscid)) match = 1'b0;
      if (s.dv && (!item.gscid_valid ||
                   ((s.dev_match & dmsk) != ({8'd0, item.gscid} & dmsk)))) match = 1'b0;
    end
    inc = {1'b0, old_v} + 65'd1;
    ovf = (eff_bits == 7'd64) ? inc[64] : inc[eff_bits[5:0]];
  end

  assign idx_ext = 6'(idx);
  assign item_pop = (state == ST_DONE) && res_ready;
  assign res_valid = state == ST_DONE;
  always_comb begin
    res.overflow_irq = irq;
    res.overflow_flags = 32'(of_flags);
    res.counted_mask = counted;
  end

  always_ff @(posedge clk) begin
    sel_rd <= sel_mem[idx];
    cnt_rd <= cnt_mem[idx];
    rd_valid <= valid_bits[idx];
    if (state == ST_IDLE && item_valid && idx_ok) begin
      if (item.kind == KIND_SEL_WR) begin
        sel_mem[item.counter_index[IdxW-1:0]] <= '{ev: item.event_id,
          proc_match: item.proc_id, dev_match: item.dev_id,
          pv: item.proc_valid, dv: item.selector_bits[2],
          idt: item.selector_bits[1], dmask: item.selector_bits[0]};
        if (!valid_bits[item.counter_index[IdxW-1:0]]) begin
          cnt_mem[item.counter_index[IdxW-1:0]] <= '0;
        end
      end else if (item.kind == KIND_CNT_WR) begin
        cnt_mem[item.counter_index[IdxW-1:0]] <= item.counter_value & wmask;
        if (!valid_bits[item.counter_index[IdxW-1:0]]) begin
          sel_mem[item.counter_index[IdxW-1:0]] <= '0;
        end
      end
    end else if (state == ST_UPD && match && !inhibit_mask[idx]) begin
      cnt_mem[idx] <= inc[63:0] & wmask;
      // first touch of an unwritten entry: its selector becomes the zero selector
      if (!rd_valid) begin
        sel_mem[idx] <= '0;
      end
    end
    if (rst) begin
      state <= ST_IDLE;
      valid_bits <= '0;
      of_flags <= '0;
      idx <= '0;
      limit <= '0;
      irq <= 1'b0;
      counted <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            irq <= 1'b0;
            counted <= '0;
            idx <= '0;
            limit <= (active_counters > 6'(NUM_COUNTERS)) ? 6'(NUM_COUNTERS)
                                                          : active_counters;
            state <= ST_DONE;
            if (item.kind == KIND_EVENT) begin
              if (hpm_enable && active_counters != 6'd0) begin
                state <= ST_READ;
              end
            end else if ((item.kind == KIND_SEL_WR || item.kind == KIND_CNT_WR)
                         && idx_ok) begin
              valid_bits[item.counter_index[IdxW-1:0]] <= 1'b1;
              of_flags[item.counter_index[IdxW-1:0]] <=
                (item.kind == KIND_SEL_WR) ? item.selector_bits[3] : 1'b0;
            end
          end
        end
        ST_READ: state <= ST_UPD;
        ST_UPD: begin
          if (match && !inhibit_mask[idx]) begin
            valid_bits[idx] <= 1'b1;
            counted[idx] <= 1'b1;
            if (ovf && !of_flags[idx]) begin
              of_flags[idx] <= 1'b1;
              irq <= 1'b1;
            end
          end
          if (idx_ext + 6'd1 >= limit) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= ST_READ;
          end
        end
        ST_DONE: if (res_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/filtered_event_counter_bank_unit.sv]
// filtered_event_counter_bank_unit: top level of the filtered event counter bank
// depends on fecb_pkg, fecb_queue, fecb_back
// An event transfer visits the first min(active_counters, NUM_COUNTERS) counters one
// at a time, each in a read state (selector and counter memory read) and then an
// update state (match and update); selector and counter writes, other kinds, and events
// while disabled or with no active counters go straight to the result. A two-entry
// queue takes new transfers while the walk runs, and the result is held until taken.
// Every transfer gives one result. No clearing pass: a per-counter valid bit makes
// unwritten entries read as zero.
module filtered_event_counter_bank_unit #(
  parameter int unsigned NUM_COUNTERS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  fecb_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output fecb_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  fecb_pkg::cfg_item_t cfg_data
);
  import fecb_pkg::*;

  // configuration registers
  logic hpm_enable;
  logic [31:0] inhibit_mask;
  logic [5:0] active_counters;
  logic [6:0] counter_bits;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      hpm_enable <= 1'b0;
      inhibit_mask <= '0;
      active_counters <= 6'd32;
      counter_bits <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_data.cfg_index)
        {1'b0, CFG_HPM_ENABLE}: hpm_enable <= cfg_data.cfg_data[0];
        {1'b0, CFG_INHIBIT}: inhibit_mask <= cfg_data.cfg_data[31:0];
        {1'b0, CFG_ACTIVE}: active_counters <= cfg_data.cfg_data[5:0];
        {1'b0, CFG_BITS}: counter_bits <= cfg_data.cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // front: queue of accepted transfers
  logic q_full;
  logic q_ne;
  logic q_pop;
  in_item_t q_item;

  assign in_ready = !q_full;

  fecb_queue u_queue (
    .clk(clk), .rst(rst),
    .push(in_valid && !q_full), .push_data(in_data), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .pop_data(q_item)
  );

  // back: counter walk
  fecb_back #(.NUM_COUNTERS(NUM_COUNTERS)) u_back (
    .clk(clk), .rst(rst),
    .item_valid(q_ne), .item(q_item), .item_pop(q_pop),
    .hpm_enable(hpm_enable), .inhibit_mask(inhibit_mask),
    .active_counters(active_counters), .counter_bits(counter_bits),
    .res_valid(out_valid), .res_ready(out_ready), .res(out_data)
  );

  // nothing counts while the monitor is disabled
  a_no_count_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hpm_enable && $stable(hpm_enable) |-> out_data.counted_mask == '0)
    else $error("counted with monitor disabled");
  a_irq_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow_irq |-> out_data.counted_mask != '0)
    else $error("irq without count");
  a_pop_out: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> out_valid && out_ready)
    else $error("queue popped without result transfer");
endmodule

[dv/filtered_event_counter_bank_unit_test.sv]
// testbench of the filtered event counter bank: random and directed items against
// a built-in predictor of counters, selectors and overflow flags
// depends on fecb_pkg and filtered_event_counter_bank_unit
`timescale 1ns / 100ps

module filtered_event_counter_bank_unit_test;
  import fecb_pkg::*;

  localparam int NumCnt = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_item_t cfg_data = '0;

  filtered_event_counter_bank_unit #(.NUM_COUNTERS(NumCnt)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the block state
  logic        pr_enable;
  logic [31:0] pr_inhibit;
  logic [5:0]  pr_active;
  logic [6:0]  pr_bits;
  logic [63:0] pr_count [NumCnt];
  sel_t        pr_sel [NumCnt];
  logic        pr_of [NumCnt];

  in_item_t  pending_items [$];
  cfg_item_t pending_cfg [$];
  out_item_t expected_results [$];
  int errors = 0;
  int n_events = 0;
  int n_irqs = 0;
  bit long_stall = 1'b0;

  // selector filter, partial device match with dmask
  function automatic bit sel_hit(int i, in_item_t it);
    logic [23:0] d, m;
    sel_t s;
    s = pr_sel[i];
    d = s.dev_match;
    m = s.dmask ? (~((d + 24'd1) ^ d) & DevMask) : DevMask;
    if (s.ev != it.event_id) return 0;
    if (!s.idt) begin
      if (s.pv && (!it.proc_valid || s.proc_match != it.proc_id)) return 0;
      if (s.dv && ((d & m) != (it.dev_id & m))) return 0;
    end else begin
      if (s.pv && (!it.pscid_valid || s.proc_match != it.pscid)) return 0;
      if (s.dv && (!it.gscid_valid || (d & m) != ({8'd0, it.gscid} & m))) return 0;
    end
    return 1;
  endfunction

  function automatic out_item_t bank_step(in_item_t it);
    out_item_t r;
    int b, n;
    logic [63:0] wm, old;
    logic [64:0] nxt;
    bit ovf;
    r = '0;
    b = (pr_bits == 0) ? 1 : (pr_bits > 64) ? 64 : pr_bits;
    wm = (b >= 64) ? '1 : ((64'd1 << b) - 64'd1);
    case (kind_t'(it.kind))
      KIND_EVENT: begin
        if (pr_enable) begin
          n = (pr_active > NumCnt) ? NumCnt : pr_active;
          for (int i = 0; i < n; i++) begin
            if (!pr_inhibit[i] && sel_hit(i, it)) begin
              old = pr_count[i];
              nxt = {1'b0, old} + 65'd1;
              ovf = (b >= 64) ? nxt[64] : nxt[b];
              pr_count[i] = nxt[63:0] & wm;
              r.counted_mask[i] = 1'b1;
              if (ovf && !pr_of[i]) begin
                pr_of[i] = 1'b1;
                r.overflow_irq = 1'b1;
              end
            end
          end
        end
      end
      KIND_SEL_WR: begin
        pr_sel[it.counter_index] = '{ev: it.event_id, proc_match: it.proc_id,
          dev_match: it.dev_id, pv: it.proc_valid, dv: it.selector_bits[2],
          idt: it.selector_bits[1], dmask: it.selector_bits[0]};
        pr_of[it.counter_index] = it.selector_bits[3];
      end
      KIND_CNT_WR: begin
        pr_count[it.counter_index] = it.counter_value & wm;
        pr_of[it.counter_index] = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < NumCnt; i++) r.overflow_flags[i] = pr_of[i];
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(bank_step(in_data));
        if (kind_t'(in_data.kind) == KIND_EVENT) n_events++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // configuration writes, only issued while the block is idle
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_data.cfg_index[1:0]))
          CFG_HPM_ENABLE: pr_enable = cfg_data.cfg_data[0];
          CFG_INHIBIT:    pr_inhibit = cfg_data.cfg_data[31:0];
          CFG_ACTIVE:     pr_active = cfg_data.cfg_data[5:0];
          default:        pr_bits = cfg_data.cfg_data[6:0];
        endcase
      end
      if (!cfg_valid || cfg_ready) begin
        if (pending_cfg.size() > 0) begin
          cfg_data <= pending_cfg.pop_front();
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold-off
  int stall_phase = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= stall_phase + 1;
      if (long_stall && hold_left == 0) hold_left <= 400;
      if (hold_left > 0) begin
        hold_left <= (hold_left == 1) ? -1 : hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_phase[8]) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= (stall_phase % 7 < 4) || ($urandom_range(0, 3) == 0);
      end
    end
  end

  // monitor: compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (want.overflow_irq) n_irqs++;
        if (out_data.overflow_irq !== want.overflow_irq)
          $display("%0t: overflow_irq expected %b actual %b", $time,
                   want.overflow_irq, out_data.overflow_irq);
        if (out_data.overflow_flags !== want.overflow_flags)
          $display("%0t: overflow_flags expected %h actual %h", $time,
                   want.overflow_flags, out_data.overflow_flags);
        if (out_data.counted_mask !== want.counted_mask)
          $display("%0t: counted_mask expected %h actual %h", $time,
                   want.counted_mask, out_data.counted_mask);
        if (out_data !== want) errors++;
      end
    end
  end

  function automatic in_item_t rand_item();
    in_item_t it;
    it = '0;
    it.kind = 2'($urandom_range(0, 3));
    it.counter_index = 5'($urandom);
    it.event_id = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 3));
    it.proc_valid = 1'($urandom);
    it.proc_id = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 3));
    it.pscid_valid = 1'($urandom);
    it.pscid = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 3));
    it.dev_id = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 7));
    it.gscid_valid = 1'($urandom);
    it.gscid = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    it.selector_bits = 4'($urandom);
    // values near the wrap point make overflows frequent
    case ($urandom_range(0, 3))
      0: it.counter_value = {$urandom, $urandom};
      1: it.counter_value = '1 - 64'($urandom_range(0, 4));
      default: it.counter_value = 64'($urandom_range(0, 3)) << $urandom_range(0, 63)
                                  | (64'd1 << $urandom_range(0, 63)) - 64'd1;
    endcase
    // events are the common case
    if ($urandom_range(0, 1) == 0) it.kind = KIND_EVENT;
    return it;
  endfunction

  function automatic cfg_item_t cfg_word(cfg_index_t idx, logic [63:0] v);
    cfg_item_t c;
    c.cfg_index = {1'b0, idx};
    c.cfg_data = v;
    return c;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(logic en, logic [31:0] inh, logic [5:0] act, logic [6:0] wb);
    pending_cfg.push_back(cfg_word(CFG_HPM_ENABLE, {63'd0, en}));
    pending_cfg.push_back(cfg_word(CFG_INHIBIT, {32'hDEAD0000, inh}));
    pending_cfg.push_back(cfg_word(CFG_ACTIVE, {58'd0, act}));
    pending_cfg.push_back(cfg_word(CFG_BITS, {57'd0, wb}));
    while (pending_cfg.size() > 0 || cfg_valid) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    in_item_t it;
    pr_enable = 1'b0;
    pr_inhibit = '0;
    pr_active = 6'd32;
    pr_bits = 7'd64;
    for (int i = 0; i < NumCnt; i++) begin
      pr_count[i] = '0;
      pr_sel[i] = '0;
      pr_of[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // event while disabled, then enable at full width
    pending_items.push_back('0);
    wait_idle();
    write_cfg(1'b1, 32'd0, 6'd32, 7'd64);
    // directed: 64-bit carry, plain, pid, device dmask, idt forms, kind 3
    it = '0; it.kind = KIND_CNT_WR; it.counter_index = 5'd31; it.counter_value = '1;
    pending_items.push_back(it);
    it = '0; it.kind = KIND_SEL_WR; it.counter_index = 5'd31; it.event_id = 15'h7FFF;
    pending_items.push_back(it);
    it = '0; it.kind = KIND_EVENT; it.event_id = 15'h7FFF;
    pending_items.push_back(it);
    pending_items.push_back(it);
    it = '0; it.kind = KIND_SEL_WR; it.counter_index = 5'd1; it.event_id = 15'd1;
    it.proc_valid = 1'b1; it.proc_id = 20'hFFFFF; it.dev_id = 24'h0000FB;
    it.selector_bits = 4'b0101;
    pending_items.push_back(it);
    it = '0; it.kind = KIND_EVENT; it.event_id = 15'd1; it.proc_valid = 1'b1;
    it.proc_id = 20'hFFFFF; it.dev_id = 24'h0000F8;
    pending_items.push_back(it);
    it.proc_valid = 1'b0;
    pending_items.push_back(it);
    it = '0; it.kind = KIND_SEL_WR; it.counter_index = 5'd2; it.event_id = 15'd1;
    it.proc_valid = 1'b1; it.proc_id = 20'd5; it.dev_id = 24'hFFFFFF;
    it.selector_bits = 4'b0111;
    pending_items.push_back(it);
    it = '0; it.kind = KIND_EVENT; it.event_id = 15'd1; it.pscid_valid = 1'b1;
    it.pscid = 20'd5; it.gscid_valid = 1'b1; it.gscid = 16'hFFFF; it.dev_id = '1;
    pending_items.push_back(it);
    it.gscid_valid = 1'b0;
    pending_items.push_back(it);
    it = '0; it.kind = KIND_NONE; it.counter_index = 5'd3; it.counter_value = '1;
    pending_items.push_back(it);
    it = '0; it.kind = KIND_SEL_WR; it.counter_index = 5'd4; it.selector_bits = 4'b1000;
    pending_items.push_back(it);
    wait_idle();

    // random phases across register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_cfg(1'b1, 32'd0, 6'd32, 7'd3);
        1: write_cfg(1'b1, 32'hFFFFFFFF, 6'd63, 7'd1);
        2: write_cfg(1'b1, $urandom, 6'd0, 7'd0);
        3: write_cfg(1'b0, 32'd0, 6'd32, 7'd2);
        4: write_cfg(1'b1, $urandom & $urandom, 6'($urandom_range(1, 32)), 7'd127);
        5: write_cfg(1'b1, 32'd0, 6'd8, 7'd64);
        6: write_cfg(1'b1, 32'h0000FFFF, 6'd32, 7'($urandom_range(1, 64)));
        default: write_cfg(1'b1, 32'd0, 6'd32, 7'd4);
      endcase
      if (ph == 5) long_stall = 1'b1;
      for (int k = 0; k < 170; k++) pending_items.push_back(rand_item());
      wait_idle();
      long_stall = 1'b0;
    end

    $display("covered %0d events with %0d overflow interrupts over 8 register settings",
             n_events, n_irqs);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/core/fecb_pkg.sv
rtl/core/fecb_queue.sv
rtl/core/fecb_back.sv
rtl/core/filtered_event_counter_bank_unit.sv
dv/filtered_event_counter_bank_unit_test.sv
